// File: hw/rtl/gftc_pkg.sv
// Package for the gas fill to current loop unit.
// Holds state and register index types, fixed-point constants and unit widths.
// No dependencies.
`default_nettype none
package gftc_pkg;

    localparam int DAC_BITS = 14;
    localparam logic [17:0] DAC_MAX = 18'((1 << DAC_BITS) - 1);

    localparam logic signed [16:0] REF_OFS = 17'sd27300;
    localparam logic signed [16:0] TK_OFS  = 17'sd27315;
    localparam logic [15:0] PCT_SCALE = 16'd10000;
    localparam logic [17:0] FILL_MAX  = 18'd10000;
    localparam logic [17:0] LVAL_MAX  = 18'd65535;
    localparam logic [16:0] UA_ZERO   = 17'd4000;
    localparam logic [32:0] DAC_DIV   = 33'd256000;
    localparam logic [32:0] UA_DIV    = 33'd5;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_C_W = $clog2(MUL_B_W + 1);

    localparam int DIV_N_W = 46;
    localparam int DIV_D_W = 33;
    localparam int DIV_Q_W = 18;
    localparam int DIV_S_W = DIV_D_W + DIV_Q_W;
    localparam int DIV_C_W = $clog2(DIV_Q_W + 1);

    localparam logic [DIV_C_W-1:0] QB_FILL = DIV_C_W'(14);
    localparam logic [DIV_C_W-1:0] QB_LOOP = DIV_C_W'(16);
    localparam logic [DIV_C_W-1:0] QB_UA   = DIV_C_W'(17);
    localparam logic [DIV_C_W-1:0] QB_DAC  = DIV_C_W'(15);

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_REF_TEMP   = 3'd0,
        REG_FULL_PRESS = 3'd1,
        REG_ZERO_PRESS = 3'd2,
        REG_FILL_SCALE = 3'd3,
        REG_DAC_OFFSET = 3'd4,
        REG_DAC_GAIN   = 3'd5,
        REG_HOLD_TICKS = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RP,
        S_NUM,
        S_DEN,
        S_DIVF,
        S_SCALE,
        S_FF,
        S_Z,
        S_DIVL,
        S_DIVU,
        S_MDAC,
        S_DIVD,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/gftc_if.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on nothing.
`default_nettype none
interface gftc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temp_c;
    logic [15:0]        pressure_in;
    logic               sim_active;
    logic               start_hold;

    modport source (output valid, temp_c, pressure_in, sim_active, start_hold, input ready);
    modport sink   (input valid, temp_c, pressure_in, sim_active, start_hold, output ready);
endinterface

interface gftc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] fill_percent;
    logic [16:0] loop_current_ua;
    logic [13:0] dac_code;
    logic        held;
    logic [15:0] pressure_used;

    modport source (output valid, fill_percent, loop_current_ua, dac_code, held,
                    pressure_used, input ready);
    modport sink   (input valid, fill_percent, loop_current_ua, dac_code, held,
                    pressure_used, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gftc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on gftc_pkg.
`default_nettype none
module gftc_mul
    import gftc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output logic                    o_done,
    output logic [MUL_P_W-1:0]      o_prod
);
    logic               r_busy;
    logic [MUL_C_W-1:0] r_cnt;
    logic [MUL_P_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= MUL_C_W'(MUL_B_W);
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= MUL_P_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && r_cnt != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// File: hw/rtl/gftc_div.sv
// Restoring divider, one quotient bit per cycle; it forms i_qbits + 1 quotient bits.
// Depends on gftc_pkg.
`default_nettype none
module gftc_div
    import gftc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIV_N_W-1:0] i_num,
    input  wire logic [DIV_D_W-1:0] i_den,
    input  wire logic [DIV_C_W-1:0] i_qbits,
    output logic                    o_done,
    output logic [DIV_Q_W-1:0]      o_quot
);
    logic               r_busy;
    logic [DIV_C_W-1:0] r_cnt;
    logic [DIV_N_W-1:0] r_rem;
    logic [DIV_S_W-1:0] r_dsh;
    logic [DIV_Q_W-1:0] r_q;
    logic [DIV_S_W-1:0] rem_ext;
    logic [DIV_S_W-1:0] diff;
    logic               ge;

    assign rem_ext = DIV_S_W'(r_rem);
    assign ge      = rem_ext >= r_dsh;
    assign diff    = rem_ext - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_qbits + 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= DIV_S_W'(i_den) << i_qbits;
            r_q   <= '0;
        end else if (r_busy && r_cnt != '0) begin
            if (ge) begin
                r_rem <= diff[DIV_N_W-1:0];
            end
            r_q   <= {r_q[DIV_Q_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_q;
endmodule
`default_nettype wire

// File: hw/rtl/gas_fill_to_current_loop_unit.sv
// Gas-law fill level to 4-20 mA loop current and DAC code, one sample word at a time.
// The steps run in order; the DAC multiply and divide are skipped when the code is held,
// the fill divide when the fill needs no division, and the loop divide when the loop
// numerator is not positive or full pressure is not above zero pressure; a stalled result
// holds the input off. Built on the shared bit-serial multiplier and restoring divider.
// Sync active-low reset: defaults, idle.
`default_nettype none
module gas_fill_to_current_loop_unit
    import gftc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gftc_in_if.sink                i_in,
    gftc_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    logic [15:0] r_ref_temp, r_full, r_zero, r_scale, r_gain, r_hold_ticks;
    logic [13:0] r_dac_ofs;
    logic [15:0] r_latched, r_hc;
    logic [13:0] r_last_dac;

    t_state             r_state, n_state;
    logic [15:0]        r_p;
    logic signed [16:0] r_tk;
    logic               r_held;
    logic [DIV_N_W-1:0] r_num;
    logic [15:0]        r_fill;
    logic [31:0]        r_lnum;
    logic [16:0]        r_ua;

    logic        r_ovalid;
    logic [15:0] r_o_fill, r_o_p;
    logic [16:0] r_o_ua;
    logic [13:0] r_o_dac;
    logic        r_o_held;

    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    logic               div_start, div_done;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic [DIV_C_W-1:0] div_qb;
    logic [DIV_Q_W-1:0] div_q;

    logic signed [16:0] rk, tk_in, tk_sel;
    logic [15:0]        rk_mag, tk_mag, p_sel, hc_ld;
    logic               in_acc, out_go, wr_en;
    logic               need_div;
    logic [13:0]        fq_short, q_fill;
    logic [15:0]        fill_now, lval_q;
    logic               lnum_pos;
    logic [31:0]        lnum_diff;
    logic [17:0]        code_sum;
    logic [13:0]        code_sat;

    gftc_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    gftc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .i_qbits(div_qb),
        .o_done (div_done),
        .o_quot (div_q)
    );

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_temp   <= 16'd2000;
            r_full       <= 16'd65535;
            r_zero       <= 16'd0;
            r_scale      <= 16'd16384;
            r_dac_ofs    <= 14'd0;
            r_gain       <= 16'd256;
            r_hold_ticks <= 16'd0;
        end else if (wr_en) begin
            case (paddr[ADDR_W-1:2])
                REG_REF_TEMP:   r_ref_temp   <= pwdata[15:0];
                REG_FULL_PRESS: r_full       <= pwdata[15:0];
                REG_ZERO_PRESS: r_zero       <= pwdata[15:0];
                REG_FILL_SCALE: r_scale      <= pwdata[15:0];
                REG_DAC_OFFSET: r_dac_ofs    <= pwdata[13:0];
                REG_DAC_GAIN:   r_gain       <= pwdata[15:0];
                REG_HOLD_TICKS: r_hold_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_REF_TEMP:   prdata = 32'(r_ref_temp);
            REG_FULL_PRESS: prdata = 32'(r_full);
            REG_ZERO_PRESS: prdata = 32'(r_zero);
            REG_FILL_SCALE: prdata = 32'(r_scale);
            REG_DAC_OFFSET: prdata = 32'(r_dac_ofs);
            REG_DAC_GAIN:   prdata = 32'(r_gain);
            REG_HOLD_TICKS: prdata = 32'(r_hold_ticks);
            default:        prdata = '0;
        endcase
    end

    // datapath helpers
    assign rk      = $signed({r_ref_temp[15], r_ref_temp}) + REF_OFS;
    assign tk_in   = $signed({i_in.temp_c[15], i_in.temp_c}) + TK_OFS;
    assign tk_sel  = i_in.sim_active ? rk : tk_in;
    assign p_sel   = i_in.sim_active ? r_latched : i_in.pressure_in;
    assign rk_mag  = rk[16] ? 16'(-rk) : rk[15:0];
    assign tk_mag  = r_tk[16] ? 16'(-r_tk) : r_tk[15:0];
    assign hc_ld   = i_in.start_hold ? r_hold_ticks : r_hc;
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_go  = !r_ovalid || o_out.ready;

    always_comb begin
        need_div = 1'b0;
        fq_short = 14'd0;
        if (r_num == '0) begin
            fq_short = 14'd0;
        end else if (mul_prod[31:0] == '0) begin
            fq_short = rk[16] ? 14'd0 : FILL_MAX[13:0];
        end else if (rk[16] != r_tk[16]) begin
            fq_short = 14'd0;
        end else begin
            need_div = 1'b1;
        end
    end

    assign q_fill    = (div_q > FILL_MAX) ? FILL_MAX[13:0] : div_q[13:0];
    assign fill_now  = mul_prod[29:14];
    assign lnum_diff = r_lnum - 32'(mul_prod[29:0]);
    assign lnum_pos  = (r_full > r_zero) && (r_lnum > 32'(mul_prod[29:0]));
    assign lval_q    = (div_q > LVAL_MAX) ? LVAL_MAX[15:0] : div_q[15:0];
    assign code_sum  = 18'(r_dac_ofs) + div_q;
    assign code_sat  = (code_sum > DAC_MAX) ? DAC_MAX[13:0] : code_sum[13:0];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_qb    = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(rk_mag);
                    mul_b     = p_sel;
                    n_state   = S_RP;
                end
            end
            S_RP: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = mul_prod[MUL_A_W-1:0];
                    mul_b     = PCT_SCALE;
                    n_state   = S_NUM;
                end
            end
            S_NUM: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(r_full);
                    mul_b     = tk_mag;
                    n_state   = S_DEN;
                end
            end
            S_DEN: begin
                if (mul_done) begin
                    if (need_div) begin
                        div_start = 1'b1;
                        div_num   = r_num;
                        div_den   = DIV_D_W'(mul_prod[31:0]);
                        div_qb    = QB_FILL;
                        n_state   = S_DIVF;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = MUL_A_W'(fq_short);
                        mul_b     = r_scale;
                        n_state   = S_SCALE;
                    end
                end
            end
            S_DIVF: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(q_fill);
                    mul_b     = r_scale;
                    n_state   = S_SCALE;
                end
            end
            S_SCALE: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(fill_now);
                    mul_b     = r_full;
                    n_state   = S_FF;
                end
            end
            S_FF: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = MUL_A_W'(r_zero);
                    mul_b     = PCT_SCALE;
                    n_state   = S_Z;
                end
            end
            S_Z: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    if (lnum_pos) begin
                        div_num = DIV_N_W'(lnum_diff);
                        div_den = DIV_D_W'(r_full - r_zero);
                        div_qb  = QB_LOOP;
                        n_state = S_DIVL;
                    end else begin
                        div_num = '0;
                        div_den = UA_DIV;
                        div_qb  = QB_UA;
                        n_state = S_DIVU;
                    end
                end
            end
            S_DIVL: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = DIV_N_W'({lval_q, 3'b000});
                    div_den   = UA_DIV;
                    div_qb    = QB_UA;
                    n_state   = S_DIVU;
                end
            end
            S_DIVU: begin
                if (div_done) begin
                    if (r_held) begin
                        n_state = S_DONE;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = MUL_A_W'(div_q[16:0]);
                        mul_b     = r_gain;
                        n_state   = S_MDAC;
                    end
                end
            end
            S_MDAC: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_num   = DIV_N_W'(mul_prod[32:0]);
                    div_den   = DAC_DIV;
                    div_qb    = QB_DAC;
                    n_state   = S_DIVD;
                end
            end
            S_DIVD: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched  <= '0;
            r_hc       <= '0;
            r_last_dac <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (in_acc) begin
                if (!i_in.sim_active) begin
                    r_latched <= i_in.pressure_in;
                end
                r_hc <= (hc_ld != '0) ? hc_ld - 1'b1 : hc_ld;
            end
            if (r_state == S_DIVD && div_done) begin
                r_last_dac <= code_sat;
            end
            if (r_state == S_DONE && out_go) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working and output words
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p    <= p_sel;
            r_tk   <= tk_sel;
            r_held <= (hc_ld != '0);
        end
        if (r_state == S_NUM && mul_done) begin
            r_num <= mul_prod[DIV_N_W-1:0];
        end
        if (r_state == S_SCALE && mul_done) begin
            r_fill <= fill_now;
        end
        if (r_state == S_FF && mul_done) begin
            r_lnum <= mul_prod[31:0];
        end
        if (r_state == S_DIVU && div_done) begin
            r_ua <= UA_ZERO + div_q[16:0];
        end
        if (r_state == S_DONE && out_go) begin
            r_o_fill <= r_fill;
            r_o_ua   <= r_ua;
            r_o_dac  <= r_last_dac;
            r_o_held <= r_held;
            r_o_p    <= r_p;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.fill_percent    = r_o_fill;
    assign o_out.loop_current_ua = r_o_ua;
    assign o_out.dac_code        = r_o_dac;
    assign o_out.held            = r_o_held;
    assign o_out.pressure_used   = r_o_p;
endmodule
`default_nettype wire

// File: hw/rtl/gftc_checker.sv
// Port-level checks for the gas fill to current loop unit, attached by bind.
// Depends on gas_fill_to_current_loop_unit and gftc_if.
`default_nettype none
module gftc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_fill,
    input wire logic [16:0] i_ua
);
    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second sample word taken while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped before it was taken");

    a_ua_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_ua >= 17'd4000))
        else $error("loop current below 4 mA");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fill <= 16'd40000))
        else $error("fill percent out of range");
endmodule

bind gas_fill_to_current_loop_unit gftc_checker u_gftc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_fill     (o_out.fill_percent),
    .i_ua       (o_out.loop_current_ua)
);
`default_nettype wire
